/* rtl/iso_date_to_epoch_nanos_macros.svh */
// assertion macros shared by the date conversion block
`ifndef ISO_DATE_TO_EPOCH_NANOS_MACROS_SVH
`define ISO_DATE_TO_EPOCH_NANOS_MACROS_SVH

// same-cycle implication, checked outside reset
`define IDTN_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idtn assertion failed");

// next-cycle implication, checked outside reset
`define IDTN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idtn assertion failed");

`endif

/* rtl/idtn_pkg.sv */
// types, constants and tables for the date to epoch conversion
package idtn_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_BAD_FIELD  = 2'd2
    } t_status;

    localparam int CHARS      = 10;
    localparam int YEAR_W     = 14;
    localparam int DOY_W      = 9;
    localparam int DAYS_W     = 23;
    localparam int NANOS_W    = 64;
    localparam int QUOT_W     = 12;
    localparam int CENT_W     = 7;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] TEXT_LEN   = 8'd10;

    // year is biased by three 400-year eras so that all arithmetic stays positive
    localparam int YEAR_BIAS   = 1200;
    // 719468 plus three eras of 146097 days
    localparam int DAYS_BIAS   = 1157759;
    // floor(q / 25) as (q * 5243) >> 17, exact for q below 2800
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;
    // 86400e9 = 1318359375 << 16
    localparam logic signed [31:0] NANOS_MUL = 32'sd1318359375;
    localparam int NANOS_SHIFT = 16;
    localparam logic signed [DAYS_W-1:0] DAYS_FIT_MAX = 23'sd106751;

    // decoded first stage of one date
    typedef struct packed {
        t_status            status;
        logic [YEAR_W-1:0]  year_biased;
        logic [DOY_W-1:0]   doy;
    } t_parse;

    // days before the first of a month in a year that starts in March
    function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mp);
        logic [DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/idtn_parse.sv */
// text check and field decode for one YYYY-MM-DD date
module idtn_parse (
    input  logic [7:0]                          i_text_length,
    input  logic [idtn_pkg::CHARS-1:0][7:0]     i_text,
    output idtn_pkg::t_parse                    o_parse
);

    logic [idtn_pkg::CHARS-1:0]         w_dig;
    logic [idtn_pkg::CHARS-1:0][3:0]    w_val;
    logic                               w_year_neg;
    logic                               w_year_ok;
    logic [13:0]                        w_year_mag3;
    logic [13:0]                        w_year_mag4;
    logic signed [14:0]                 w_year;
    logic signed [14:0]                 w_year_adj;
    logic [6:0]                         w_month;
    logic [6:0]                         w_day;
    logic                               w_month_ok;
    logic                               w_day_ok;
    logic                               w_early;
    logic [3:0]                         w_mp;

    // per-character digit test and value
    always_comb begin
        for (int k = 0; k < idtn_pkg::CHARS; k++) begin
            w_dig[k] = (i_text[k] >= idtn_pkg::CHAR_ZERO) && (i_text[k] <= idtn_pkg::CHAR_NINE);
            w_val[k] = i_text[k][3:0];
        end
    end

    // year field, optional leading minus
    assign w_year_neg  = (i_text[0] == idtn_pkg::CHAR_MINUS);
    assign w_year_ok   = w_year_neg ? (&w_dig[3:1]) : (&w_dig[3:0]);
    assign w_year_mag3 = 14'(w_val[1]) * 14'd100 + 14'(w_val[2]) * 14'd10 + 14'(w_val[3]);
    assign w_year_mag4 = 14'(w_val[0]) * 14'd1000 + w_year_mag3;
    assign w_year      = w_year_neg ? -$signed({1'b0, w_year_mag3})
                                    : $signed({1'b0, w_year_mag4});

    // month and day must be two digits in range; a minus fails the digit test
    assign w_month    = 7'(w_val[5]) * 7'd10 + 7'(w_val[6]);
    assign w_day      = 7'(w_val[8]) * 7'd10 + 7'(w_val[9]);
    assign w_month_ok = w_dig[5] && w_dig[6] && (w_month >= 7'd1) && (w_month <= 7'd12);
    assign w_day_ok   = w_dig[8] && w_dig[9] && (w_day >= 7'd1) && (w_day <= 7'd31);

    // march-based year and month index
    assign w_early    = (w_month <= 7'd2);
    assign w_year_adj = w_year + 15'(idtn_pkg::YEAR_BIAS) - 15'(w_early);
    assign w_mp       = w_early ? 4'(w_month + 7'd9) : 4'(w_month - 7'd3);

    // status priority: format before fields
    always_comb begin
        if ((i_text_length != idtn_pkg::TEXT_LEN) ||
            (i_text[4] != idtn_pkg::CHAR_MINUS) || (i_text[7] != idtn_pkg::CHAR_MINUS)) begin
            o_parse.status = idtn_pkg::ST_BAD_FORMAT;
        end else if (!(w_year_ok && w_month_ok && w_day_ok)) begin
            o_parse.status = idtn_pkg::ST_BAD_FIELD;
        end else begin
            o_parse.status = idtn_pkg::ST_OK;
        end
        o_parse.year_biased = w_year_adj[idtn_pkg::YEAR_W-1:0];
        o_parse.doy = idtn_pkg::days_before_month(w_mp) + 9'(w_day) - 9'd1;
    end

endmodule

/* rtl/iso_date_to_epoch_nanos.sv */
// top level: four-stage pipeline from ISO date text to epoch days and nanoseconds
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-----------------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_text_length, i_text_char_0..9
//  output  | o_out_valid  | i_out_ready  | o_status, o_epoch_days, o_epoch_nanos,
//          |              |              | o_nanos_overflow
//
// one beat per cycle sustained while i_out_ready is high; each beat is registered in stages 1 through 4 in order
// stages: text decode, divide by 100, day sum, 23x32 nanosecond multiply
// each stage takes new data when it is empty or the stage after it moves, so bubbles close up
// a stalled output holds its beat; earlier stages keep filling until the pipe is full
// synchronous active-low reset clears the stage valid bits only
`include "iso_date_to_epoch_nanos_macros.svh"

module iso_date_to_epoch_nanos (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_text_length,
    input  logic [7:0]             i_text_char_0,
    input  logic [7:0]             i_text_char_1,
    input  logic [7:0]             i_text_char_2,
    input  logic [7:0]             i_text_char_3,
    input  logic [7:0]             i_text_char_4,
    input  logic [7:0]             i_text_char_5,
    input  logic [7:0]             i_text_char_6,
    input  logic [7:0]             i_text_char_7,
    input  logic [7:0]             i_text_char_8,
    input  logic [7:0]             i_text_char_9,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic signed [22:0]     o_epoch_days,
    output logic signed [63:0]     o_epoch_nanos,
    output logic                   o_nanos_overflow
);

    localparam int YW = idtn_pkg::YEAR_W;
    localparam int DW = idtn_pkg::DAYS_W;

    idtn_pkg::t_parse                   w_parse;

    // stage valid bits and per-stage ready
    logic                               r_v1, r_v2, r_v3, r_v4;
    logic                               w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1 payload
    idtn_pkg::t_parse                   r_s1;
    // stage 2 payload
    idtn_pkg::t_status                  r_s2_status;
    logic [YW-1:0]                      r_s2_year;
    logic [idtn_pkg::DOY_W-1:0]         r_s2_doy;
    logic [idtn_pkg::CENT_W-1:0]        r_s2_cent;
    // stage 3 payload
    idtn_pkg::t_status                  r_s3_status;
    logic signed [DW-1:0]               r_s3_days;
    logic                               r_s3_ovf;
    // stage 4 payload (output register)
    idtn_pkg::t_status                  r_s4_status;
    logic signed [DW-1:0]               r_s4_days;
    logic signed [idtn_pkg::NANOS_W-1:0] r_s4_nanos;
    logic                               r_s4_ovf;

    logic [idtn_pkg::QUOT_W-1:0]        w_q1;
    logic [23:0]                        w_recip;
    logic [idtn_pkg::QUOT_W-1:0]        w_q2;
    logic [24:0]                        w_sum;
    logic signed [DW-1:0]               w_days;
    logic signed [DW+31:0]              w_nprod;

    // text decode
    idtn_parse u_parse (
        .i_text_length (i_text_length),
        .i_text        ({i_text_char_9, i_text_char_8, i_text_char_7, i_text_char_6,
                         i_text_char_5, i_text_char_4, i_text_char_3, i_text_char_2,
                         i_text_char_1, i_text_char_0}),
        .o_parse       (w_parse)
    );

    // backpressure chain
    assign w_rdy4     = !r_v4 || i_out_ready;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 2 math: centuries = floor(floor(year / 4) / 25)
    assign w_q1    = r_s1.year_biased[YW-1:2];
    assign w_recip = 24'(w_q1) * 24'(idtn_pkg::RECIP_25);

    // stage 3 math: day count from the biased march year
    assign w_q2   = r_s2_year[YW-1:2];
    assign w_sum  = 25'(r_s2_year) * 25'd365 + 25'(w_q2) + 25'(r_s2_cent[idtn_pkg::CENT_W-1:2])
                  + 25'(r_s2_doy) - 25'(r_s2_cent) - 25'(idtn_pkg::DAYS_BIAS);
    assign w_days = $signed(w_sum[DW-1:0]);

    // stage 4 math: days times 86400e9 as an odd multiply and a shift
    assign w_nprod = r_s3_days * idtn_pkg::NANOS_MUL;

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1 <= w_parse;
        end
        if (w_rdy2) begin
            r_s2_status <= r_s1.status;
            r_s2_year   <= r_s1.year_biased;
            r_s2_doy    <= r_s1.doy;
            r_s2_cent   <= idtn_pkg::CENT_W'(w_recip >> idtn_pkg::RECIP_SHIFT);
        end
        if (w_rdy3) begin
            r_s3_status <= r_s2_status;
            if (r_s2_status == idtn_pkg::ST_OK) begin
                r_s3_days <= w_days;
                r_s3_ovf  <= (w_days > idtn_pkg::DAYS_FIT_MAX) ||
                             (w_days < -idtn_pkg::DAYS_FIT_MAX);
            end else begin
                r_s3_days <= '0;
                r_s3_ovf  <= 1'b0;
            end
        end
        if (w_rdy4) begin
            r_s4_status <= r_s3_status;
            r_s4_days   <= r_s3_days;
            r_s4_nanos  <= 64'(w_nprod) << idtn_pkg::NANOS_SHIFT;
            r_s4_ovf    <= r_s3_ovf;
        end
    end

    // output beat
    assign o_out_valid      = r_v4;
    assign o_status         = r_s4_status;
    assign o_epoch_days     = r_s4_days;
    assign o_epoch_nanos    = r_s4_nanos;
    assign o_nanos_overflow = r_s4_ovf;

    // checks
    `IDTN_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != idtn_pkg::ST_OK), (o_epoch_days == '0) && (o_epoch_nanos == '0) && !o_nanos_overflow)
    `IDTN_ASSERT_IMPL(a_ovf_range, i_clk, i_rst_n, o_out_valid && o_nanos_overflow, (o_epoch_days > idtn_pkg::DAYS_FIT_MAX) || (o_epoch_days < -idtn_pkg::DAYS_FIT_MAX))
    `IDTN_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `IDTN_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_out_valid && i_out_ready && !r_v3, !o_out_valid)

endmodule
